// ===== hdl/i2c_master_transaction_engine_unit_defines.svh =====
// Assertion macros for the I2C master transaction engine.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define I2C_MTE_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("i2c_mte: implication check failed");
// next-cycle implication
`define I2C_MTE_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("i2c_mte: next-cycle check failed");
`else
`define I2C_MTE_ASSERT_IMP(name, cond, prop)
`define I2C_MTE_ASSERT_NXT(name, cond, prop)
`endif

`endif

// ===== hdl/i2c_mte_pkg.sv =====
// Shared types and constants for the I2C master transaction engine.
// No dependencies; imported by every module of the block.
package i2c_mte_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_WBA, PH_WBB, PH_WBC,
        PH_AK1, PH_AK2, PH_AK3, PH_AK4, PH_RD1, PH_RD2,
        PH_MA1, PH_MA2, PH_MA3, PH_MA4, PH_SP1, PH_SP2, PH_SP3, PH_SP4
    } phase_t;

    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_COMMAND = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // byte stage within a transaction: address, register/command, third byte
    localparam logic [1:0] STG_ADDR   = 2'd0;
    localparam logic [1:0] STG_SECOND = 2'd1;
    localparam logic [1:0] STG_THIRD  = 2'd2;

    localparam int          PADDR_W       = 3;
    localparam logic [2:0]  ADDR_DELAY    = 3'd0;
    localparam logic [15:0] DELAY_DEFAULT = 16'd100;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_byte;
        logic [7:0] byte_count;
        logic       ascending;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic [7:0] read_value;
        logic [7:0] read_slot;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

// ===== hdl/i2c_mte_regs.sv =====
// APB-style configuration register file: the step delay register.
// Depends on i2c_mte_pkg.
module i2c_mte_regs
    import i2c_mte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [15:0]        delay_cycles
);

    logic [15:0] delay_reg;
    logic [15:0] delay_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_DELAY);

    always_comb
    begin
        delay_next = delay_reg;
        if (wr_en)
        begin
            delay_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_DEFAULT;
        end
        else
        begin
            delay_reg <= delay_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_DELAY: prdata = {16'd0, delay_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign delay_cycles = delay_reg;

endmodule

// ===== hdl/i2c_mte_core.sv =====
// Bit-level bus sequencer: each item advances the step wait counter, state updated on step_en.
// Depends on i2c_mte_pkg.
module i2c_mte_core
    import i2c_mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  item_t       item,
    input  logic [15:0] delay_cycles,
    output result_t     res
);

    phase_t      phase_reg, phase_next, ent;
    logic [3:0]  bit_counter_reg, bit_counter_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] wait_counter_reg, wait_counter_next;
    logic [7:0]  held_device_reg, held_device_next;
    logic [7:0]  held_register_reg, held_register_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic [1:0]  held_op_reg, held_op_next;
    logic        held_ascending_reg, held_ascending_next;
    logic [7:0]  slot_index_reg, slot_index_next;
    logic [1:0]  stage_reg, stage_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    logic [7:0]  cnt;
    logic [15:0] limit;
    logic        do_enter;
    logic        do_load;

    always_comb
    begin
        phase_next          = phase_reg;
        bit_counter_next    = bit_counter_reg;
        bytes_left_next     = bytes_left_reg;
        shift_byte_next     = shift_byte_reg;
        wait_counter_next   = wait_counter_reg;
        held_device_next    = held_device_reg;
        held_register_next  = held_register_reg;
        held_data_next      = held_data_reg;
        held_op_next        = held_op_reg;
        held_ascending_next = held_ascending_reg;
        slot_index_next     = slot_index_reg;
        stage_next          = stage_reg;
        scl_next            = scl_reg;
        sda_next            = sda_reg;
        cnt                 = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
        limit               = (delay_cycles == 16'd0) ? 16'd1 : delay_cycles;
        do_enter            = 1'b0;
        do_load             = 1'b0;
        ent                 = PH_IDLE;
        res                 = '0;

        // request on an idle engine opens the first start step this cycle
        if (phase_reg == PH_IDLE && item.op != OP_NONE)
        begin
            held_op_next        = item.op;
            held_device_next    = item.device_address;
            held_register_next  = item.register_address;
            held_data_next      = item.write_byte;
            held_ascending_next = item.ascending;
            bytes_left_next     = cnt;
            slot_index_next     = item.ascending ? 8'd0 : cnt - 8'd1;
            stage_next          = STG_ADDR;
            phase_next          = PH_ST1;
            wait_counter_next   = 16'd0;
            scl_next            = 1'b1;
            sda_next            = 1'b1;
        end

        res.busy_res    = (phase_next != PH_IDLE);
        res.scl_release = scl_next;
        res.sda_release = sda_next;

        if (res.busy_res)
        begin
            if ({1'b0, wait_counter_next} + 17'd1 < {1'b0, limit})
            begin
                wait_counter_next = wait_counter_next + 16'd1;
            end
            else
            begin
                do_enter = 1'b1;
                unique case (phase_next)
                    PH_ST1:
                    begin
                        // line held low by someone else: skip the start
                        if (!item.sda_in)
                        begin
                            do_load = 1'b1;
                        end
                        else
                        begin
                            ent = PH_ST2;
                        end
                    end
                    PH_ST2: do_load = 1'b1;
                    PH_WBA: ent = PH_WBB;
                    PH_WBB: ent = PH_WBC;
                    PH_WBC:
                    begin
                        shift_byte_next  = {shift_byte_next[6:0], 1'b0};
                        bit_counter_next = bit_counter_next + 4'd1;
                        ent = bit_counter_next[3] ? PH_AK1 : PH_WBA;
                    end
                    PH_AK1: ent = PH_AK2;
                    PH_AK2: ent = PH_AK3;
                    PH_AK3: ent = PH_AK4;
                    PH_AK4:
                    begin
                        if (stage_next == STG_ADDR)
                        begin
                            stage_next = STG_SECOND;
                            do_load    = 1'b1;
                        end
                        else if (stage_next == STG_SECOND)
                        begin
                            if (held_op_next == OP_WRITE)
                            begin
                                stage_next = STG_THIRD;
                                do_load    = 1'b1;
                            end
                            else if (held_op_next == OP_READ)
                            begin
                                // repeated start before the read address
                                stage_next = STG_THIRD;
                                ent        = PH_ST1;
                            end
                            else
                            begin
                                ent = PH_SP1;
                            end
                        end
                        else if (held_op_next == OP_READ)
                        begin
                            shift_byte_next  = 8'd0;
                            bit_counter_next = 4'd0;
                            ent              = PH_RD1;
                        end
                        else
                        begin
                            ent = PH_SP1;
                        end
                    end
                    PH_RD1: ent = PH_RD2;
                    PH_RD2:
                    begin
                        shift_byte_next  = {shift_byte_next[6:0], item.sda_in};
                        bit_counter_next = bit_counter_next + 4'd1;
                        if (bit_counter_next[3])
                        begin
                            res.read_value = shift_byte_next;
                            res.read_slot  = slot_index_next;
                            res.read_valid = 1'b1;
                            res.read_last  = (bytes_left_next <= 8'd1);
                            ent            = PH_MA1;
                        end
                        else
                        begin
                            ent = PH_RD1;
                        end
                    end
                    PH_MA1: ent = PH_MA2;
                    PH_MA2: ent = PH_MA3;
                    PH_MA3: ent = PH_MA4;
                    PH_MA4:
                    begin
                        if (bytes_left_next > 8'd1)
                        begin
                            bytes_left_next  = bytes_left_next - 8'd1;
                            slot_index_next  = held_ascending_next ?
                                               slot_index_next + 8'd1 :
                                               slot_index_next - 8'd1;
                            shift_byte_next  = 8'd0;
                            bit_counter_next = 4'd0;
                            ent              = PH_RD1;
                        end
                        else
                        begin
                            bytes_left_next = 8'd0;
                            ent             = PH_SP1;
                        end
                    end
                    PH_SP1: ent = PH_SP2;
                    PH_SP2: ent = PH_SP3;
                    PH_SP3: ent = PH_SP4;
                    PH_SP4:
                    begin
                        res.done_res = 1'b1;
                        ent          = PH_IDLE;
                    end
                    default: ent = PH_IDLE;
                endcase
            end
        end

        // load the next outgoing byte for the current stage
        if (do_load)
        begin
            if (stage_next == STG_ADDR)
            begin
                shift_byte_next = held_device_next;
            end
            else if (stage_next == STG_SECOND)
            begin
                shift_byte_next = (held_op_next == OP_COMMAND) ? held_data_next
                                                               : held_register_next;
            end
            else
            begin
                shift_byte_next = (held_op_next == OP_READ) ? held_device_next + 8'd1
                                                            : held_data_next;
            end
            bit_counter_next = 4'd0;
            ent              = PH_WBA;
        end

        // pin changes made on entry to each step
        if (do_enter)
        begin
            phase_next        = ent;
            wait_counter_next = 16'd0;
            unique case (ent)
                PH_ST1:  begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ST2:  sda_next = 1'b0;
                PH_WBA:  scl_next = 1'b0;
                PH_WBB:  sda_next = shift_byte_next[7];
                PH_WBC:  scl_next = 1'b1;
                PH_AK1:  scl_next = 1'b0;
                PH_AK2:  sda_next = 1'b1;
                PH_AK3:  scl_next = 1'b1;
                PH_AK4:  scl_next = 1'b0;
                PH_RD1:  begin scl_next = 1'b0; sda_next = 1'b1; end
                PH_RD2:  scl_next = 1'b1;
                PH_MA1:  scl_next = 1'b0;
                PH_MA2:  sda_next = (bytes_left_next > 8'd1) ? 1'b0 : 1'b1;
                PH_MA3:  scl_next = 1'b1;
                PH_MA4:  scl_next = 1'b0;
                PH_SP1:  scl_next = 1'b0;
                PH_SP2:  sda_next = 1'b0;
                PH_SP3:  scl_next = 1'b1;
                PH_SP4:  sda_next = 1'b1;
                default: begin scl_next = 1'b1; sda_next = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            bit_counter_reg    <= 4'd0;
            bytes_left_reg     <= 8'd0;
            shift_byte_reg     <= 8'd0;
            wait_counter_reg   <= 16'd0;
            held_device_reg    <= 8'd0;
            held_register_reg  <= 8'd0;
            held_data_reg      <= 8'd0;
            held_op_reg        <= OP_NONE;
            held_ascending_reg <= 1'b0;
            slot_index_reg     <= 8'd0;
            stage_reg          <= STG_ADDR;
            scl_reg            <= 1'b1;
            sda_reg            <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            bit_counter_reg    <= bit_counter_next;
            bytes_left_reg     <= bytes_left_next;
            shift_byte_reg     <= shift_byte_next;
            wait_counter_reg   <= wait_counter_next;
            held_device_reg    <= held_device_next;
            held_register_reg  <= held_register_next;
            held_data_reg      <= held_data_next;
            held_op_reg        <= held_op_next;
            held_ascending_reg <= held_ascending_next;
            slot_index_reg     <= slot_index_next;
            stage_reg          <= stage_next;
            scl_reg            <= scl_next;
            sda_reg            <= sda_next;
        end
    end

endmodule

// ===== hdl/i2c_master_transaction_engine_unit.sv =====
// I2C master transaction engine: one transaction in, one bus cycle of results out, every
// clock cycle unless stalled. An item is registered, stepped through the bus sequencer
// and its result registered, passing the input and then the output register; a new item
// is taken each cycle while the output side keeps up; the input register fills and stalls
// only when a result waits on the output. delay_cycles sets the length of each bus step.
// Depends on i2c_mte_pkg, i2c_mte_regs, i2c_mte_core and the defines header.
`include "i2c_master_transaction_engine_unit_defines.svh"

module i2c_master_transaction_engine_unit
    import i2c_mte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         device_address,
    input  logic [7:0]         register_address,
    input  logic [7:0]         write_byte,
    input  logic [7:0]         byte_count,
    input  logic               ascending,
    input  logic               sda_in,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               scl_release,
    output logic               sda_release,
    output logic [7:0]         read_value,
    output logic [7:0]         read_slot,
    output logic               read_valid,
    output logic               read_last,
    output logic               busy_res,
    output logic               done_res
);

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg, item_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    result_t     core_res;
    logic [15:0] delay_cycles;
    logic        advance;
    logic        in_take;

    i2c_mte_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .delay_cycles (delay_cycles)
    );

    i2c_mte_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .item         (item_reg),
        .delay_cycles (delay_cycles),
        .res          (core_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            item_next     = '{op:               op,
                              device_address:   device_address,
                              register_address: register_address,
                              write_byte:       write_byte,
                              byte_count:       byte_count,
                              ascending:        ascending,
                              sda_in:           sda_in};
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            res_next       = core_res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = res_reg.scl_release;
    assign sda_release = res_reg.sda_release;
    assign read_value  = res_reg.read_value;
    assign read_slot   = res_reg.read_slot;
    assign read_valid  = res_reg.read_valid;
    assign read_last   = res_reg.read_last;
    assign busy_res    = res_reg.busy_res;
    assign done_res    = res_reg.done_res;

    `I2C_MTE_ASSERT_IMP(a_read_needs_busy, out_valid_reg && res_reg.read_valid, res_reg.busy_res)
    `I2C_MTE_ASSERT_IMP(a_done_not_read, out_valid_reg && res_reg.done_res, !res_reg.read_valid)
    `I2C_MTE_ASSERT_IMP(a_stall_only_full, in_stall, in_valid_reg && out_valid_reg)
    `I2C_MTE_ASSERT_NXT(a_advance_fills_out, advance, out_valid_reg)

endmodule
